@@ hw/rtl/jhse_pkg.sv @@
// Shared types and constants for the joint homing and sine excitation block.
`timescale 1ns / 1ps

package jhse_pkg;

    localparam int MAX_JOINTS = 7;
    localparam int ANGLE_W    = 28;
    localparam int NUM_TERMS  = 6;

    localparam logic [30:0] Q30         = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [63:0] TURN_BASE   = 64'd293589050359099;

    localparam logic signed [27:0] CMD_MAX = 28'sh7FF_FFFF;
    localparam logic signed [27:0] CMD_MIN = -28'sh800_0000;
    localparam logic [22:0]        SPEED_MAX = 23'h7F_FFFF;

    localparam int AMP_MILLI   [MAX_JOINTS] = '{2870, 1900, 2870, 2000, 2870, 2000, 2870};
    localparam int OMEGA_MILLI [MAX_JOINTS] = '{900, -239, 427, 441, 300, 400, 500};
    localparam int PHI_MILLI   [MAX_JOINTS] = '{0, 120, 140, 311, 120, 137, 710};

    // Series divisors 156, 110, 72, 42, 20, 6 as exact reciprocals for 32-bit dividends.
    localparam logic [32:0] RECIP_M [NUM_TERMS] = '{
        33'(((64'd1 << 40) + 64'd155) / 64'd156),
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 35) + 64'd5) / 64'd6)
    };
    localparam logic [5:0] RECIP_S [NUM_TERMS] = '{6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd35};

    // Control from the sequencer to every lane.
    typedef struct packed {
        logic start;
        logic excite;
    } lane_ctl_t;

    // What one lane reports back to the merge stage.
    typedef struct packed {
        logic                done;
        logic                active;
        logic signed [27:0]  cmd;
        logic [55:0]         square;
    } lane_res_t;

    function automatic logic signed [27:0] sat28(input logic signed [34:0] x);
        logic signed [27:0] r;
        if (x > 35'(CMD_MAX)) begin
            r = CMD_MAX;
        end else if (x < 35'(CMD_MIN)) begin
            r = CMD_MIN;
        end else begin
            r = x[27:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/jhse_lane.sv @@
// One joint lane: homing step or sine excitation value for its joint.
`timescale 1ns / 1ps

module jhse_lane
    import jhse_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int LANE            = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctl_t          ctl,
    input  logic signed [27:0] meas,
    input  logic signed [27:0] cmd_old,
    input  logic [22:0]        ramp,
    input  logic [31:0]        tick_period,
    input  logic [31:0]        count,
    input  logic [31:0]        count_ref,
    output lane_res_t          res
);

    localparam int OMEGA  = OMEGA_MILLI[LANE];
    localparam int OM_ABS = (OMEGA < 0) ? -OMEGA : OMEGA;
    localparam logic [63:0] D_MAG = (64'(OM_ABS) * TURN_BASE + 64'd500) / 64'd1000;
    localparam logic [63:0] D_VAL = (OMEGA < 0) ? (64'd0 - D_MAG) : D_MAG;
    localparam logic [31:0] D_LO  = D_VAL[31:0];
    localparam logic [31:0] D_HI  = D_VAL[63:32];
    localparam logic [31:0] AMP_Q =
        32'(((64'(AMP_MILLI[LANE]) << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [41:0] PHI_10K = 42'(64'(PHI_MILLI[LANE]) * 64'd10000);
    localparam logic [9:0]  OM_U    = 10'(OM_ABS);
    localparam logic signed [29:0] BAND =
        30'(((64'd1 << (ANGLE_FRAC_BITS + 1))) / 64'd10);

    typedef enum logic [3:0] {
        L_IDLE, L_HOME, L_HOME_FIN, L_PHASE, L_QUAD, L_Y, L_Y2,
        L_TMUL, L_TDIV, L_SIN, L_AMP, L_FIN
    } lane_state_t;

    lane_state_t        state_reg;
    logic               done_reg;
    logic               active_reg;
    logic signed [27:0] cmd_reg;
    logic [55:0]        square_reg;
    logic [59:0]        prod_reg;
    logic               sub_reg;
    logic [63:0]        pa_reg;
    logic [31:0]        pb_reg;
    logic [30:0]        f_reg;
    logic               neg_reg;
    logic [30:0]        y_reg;
    logic [31:0]        y2_reg;
    logic [30:0]        t_reg;
    logic [31:0]        p_reg;
    logic [31:0]        s_reg;
    logic [31:0]        m_reg;
    logic [2:0]         k_reg;

    logic signed [29:0] meas_x;
    logic               outside;
    logic [27:0]        meas_abs;
    logic [27:0]        mag;
    logic [28:0]        step;
    logic signed [34:0] home_sum;
    logic [31:0]        phase_top;
    logic [29:0]        frac;
    logic [65:0]        div_prod;
    logic [65:0]        div_q;
    logic signed [55:0] sq_s;
    logic signed [34:0] exc_val;

    always_comb begin
        meas_x   = 30'(meas);
        outside  = (meas_x > BAND) || (meas_x < -BAND);
        meas_abs = meas[27] ? 28'(~meas + 28'sd1) : 28'(meas);
        mag      = outside ? {5'd0, ramp} : meas_abs;
        sq_s     = 56'(meas) * 56'(meas);
        step     = 29'((61'(prod_reg) + 61'(64'd1 << 31)) >> 32);
        home_sum = sub_reg ? (35'(cmd_old) - 35'(step)) : (35'(cmd_old) + 35'(step));
        phase_top = pa_reg[63:32] + pb_reg;
        frac      = phase_top[29:0];
        div_prod  = 66'(p_reg) * 66'(RECIP_M[k_reg]);
        div_q     = div_prod >> RECIP_S[k_reg];
        exc_val   = neg_reg ? -35'(m_reg) : 35'(m_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == L_HOME_FIN) || (state_reg == L_FIN);
            unique case (state_reg)
                L_IDLE: begin
                    if (ctl.start) begin
                        state_reg <= ctl.excite ? L_PHASE : L_HOME;
                    end
                end
                L_HOME: begin
                    prod_reg   <= 60'(mag) * 60'(tick_period);
                    sub_reg    <= !meas[27];
                    square_reg <= 56'(sq_s);
                    state_reg  <= L_HOME_FIN;
                end
                L_HOME_FIN: begin
                    cmd_reg   <= sat28(home_sum);
                    state_reg <= L_IDLE;
                end
                L_PHASE: begin
                    pa_reg     <= 64'(D_LO) * 64'(count);
                    pb_reg     <= 32'(64'(D_HI) * 64'(count));
                    active_reg <= PHI_10K <= (42'(OM_U) * 42'(count_ref));
                    state_reg  <= L_QUAD;
                end
                L_QUAD: begin
                    // odd quadrants run the fraction backward
                    f_reg     <= phase_top[30] ? (Q30 - 31'(frac)) : 31'(frac);
                    neg_reg   <= phase_top[31];
                    state_reg <= L_Y;
                end
                L_Y: begin
                    y_reg     <= 31'((62'(f_reg) * 62'(HALF_PI_Q30)) >> 30);
                    state_reg <= L_Y2;
                end
                L_Y2: begin
                    y2_reg    <= 32'((62'(y_reg) * 62'(y_reg)) >> 30);
                    t_reg     <= Q30;
                    k_reg     <= 3'd0;
                    state_reg <= L_TMUL;
                end
                L_TMUL: begin
                    p_reg     <= 32'((63'(y2_reg) * 63'(t_reg)) >> 30);
                    state_reg <= L_TDIV;
                end
                L_TDIV: begin
                    t_reg <= Q30 - 31'(div_q);
                    k_reg <= k_reg + 3'd1;
                    state_reg <= (k_reg == 3'(NUM_TERMS - 1)) ? L_SIN : L_TMUL;
                end
                L_SIN: begin
                    s_reg     <= 32'((62'(y_reg) * 62'(t_reg)) >> 30);
                    state_reg <= L_AMP;
                end
                L_AMP: begin
                    m_reg     <= 32'((65'(64'(AMP_Q) * 64'(s_reg)) + 65'(64'd1 << 29)) >> 30);
                    state_reg <= L_FIN;
                end
                L_FIN: begin
                    cmd_reg   <= sat28(exc_val);
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign res = '{done: done_reg, active: active_reg, cmd: cmd_reg, square: square_reg};

endmodule

@@ hw/rtl/joint_homing_and_sine_excitation_top.sv @@
// Top level: tick sequencer, joint lanes, merge stage and result register.
`timescale 1ns / 1ps
//
// Each accepted request on s_* is one control tick: a mode flag and seven
// measured joint angles. A monitor tick (s_command_mode low) copies the angles
// into the joint commands and gives no result. A command tick gives
// one result on m_*: seven commanded angles and the homing flag after the tick.
// Configuration writes go through cfg_valid/cfg_ready (always ready), with
// cfg_index 0 tick_period, 1 speed_step, 2 speed_cap; other indexes are ignored.
// One lane per joint works in parallel. In a homing tick the ramp speed is
// stepped once per joint, the lanes then compute their homing steps, and the
// merge stage adds the squared angles one joint a cycle.
// The length of an excitation tick is set by the lane's sine series (six
// steps, each a multiply state and a reciprocal state).
// One tick is in work at a time; s_ready is high only while idle.
// If the receiver stalls, a finished result waits in the output register and
// the next tick is still accepted; its result waits until the register frees.
// Reset restores the default registers, homing mode, zero speed, zero commands
// and counters, and an empty output register.

module joint_homing_and_sine_excitation_top
    import jhse_pkg::*;
#(
    parameter int NUM_JOINTS      = 7,
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command_mode,
    input  logic signed [27:0] s_meas_j0,
    input  logic signed [27:0] s_meas_j1,
    input  logic signed [27:0] s_meas_j2,
    input  logic signed [27:0] s_meas_j3,
    input  logic signed [27:0] s_meas_j4,
    input  logic signed [27:0] s_meas_j5,
    input  logic signed [27:0] s_meas_j6,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [27:0] m_cmd_j0,
    output logic signed [27:0] m_cmd_j1,
    output logic signed [27:0] m_cmd_j2,
    output logic signed [27:0] m_cmd_j3,
    output logic signed [27:0] m_cmd_j4,
    output logic signed [27:0] m_cmd_j5,
    output logic signed [27:0] m_cmd_j6,
    output logic               m_homing_active
);

    localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [1:0] REG_SPEED_STEP  = 2'd1;
    localparam logic [1:0] REG_SPEED_CAP   = 2'd2;
    localparam logic [56:0] NORM_THR =
        57'(((64'd1 << (2 * ANGLE_FRAC_BITS)) + 64'd999999) / 64'd1000000);
    localparam logic [2:0] LAST_JOINT = 3'(NUM_JOINTS - 1);

    typedef enum logic [2:0] {T_IDLE, T_RAMP, T_LANES, T_MERGE, T_OUT} top_state_t;

    top_state_t         state_reg;
    logic [31:0]        tick_period_reg;
    logic [15:0]        speed_step_reg;
    logic [23:0]        speed_cap_reg;
    logic               homing_reg;
    logic [22:0]        ramp_reg;
    logic [2:0]         k_reg;
    logic               start_reg;
    logic [56:0]        sum_reg;
    logic signed [27:0] meas_reg     [MAX_JOINTS];
    logic signed [27:0] cmd_reg      [MAX_JOINTS];
    logic [31:0]        cnt_reg      [MAX_JOINTS];
    logic [22:0]        lane_ramp_reg[MAX_JOINTS];
    logic               m_valid_reg;
    logic signed [27:0] out_cmd_reg  [MAX_JOINTS];
    logic               out_homing_reg;

    logic signed [27:0] in_meas [MAX_JOINTS];
    lane_res_t          lane_res[MAX_JOINTS];
    lane_ctl_t          ctl;
    logic               all_done;
    logic [23:0]        ramp_sum;
    logic [22:0]        ramp_next;
    logic [56:0]        sum_next;
    logic               start_next;
    logic               out_load;

    assign in_meas[0] = s_meas_j0;
    assign in_meas[1] = s_meas_j1;
    assign in_meas[2] = s_meas_j2;
    assign in_meas[3] = s_meas_j3;
    assign in_meas[4] = s_meas_j4;
    assign in_meas[5] = s_meas_j5;
    assign in_meas[6] = s_meas_j6;

    assign ctl = '{start: start_reg, excite: !homing_reg};

    genvar g;
    generate
        for (g = 0; g < MAX_JOINTS; g++) begin : g_lane
            if (g < NUM_JOINTS) begin : g_on
                // joint 0 has no phase delay, so it always advances first
                jhse_lane #(
                    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
                    .LANE           (g)
                ) u_lane (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctl        (ctl),
                    .meas       (meas_reg[g]),
                    .cmd_old    (cmd_reg[g]),
                    .ramp       (lane_ramp_reg[g]),
                    .tick_period(tick_period_reg),
                    .count      (cnt_reg[g]),
                    .count_ref  ((g == 0) ? cnt_reg[0] : (cnt_reg[0] + 32'd1)),
                    .res        (lane_res[g])
                );
            end else begin : g_off
                assign lane_res[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        all_done = 1'b1;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            all_done = all_done & lane_res[j].done;
        end
        ramp_sum  = {1'b0, ramp_reg} + 24'(speed_step_reg);
        if ({1'b0, ramp_reg} < speed_cap_reg) begin
            ramp_next = (ramp_sum > 24'(SPEED_MAX)) ? SPEED_MAX : ramp_sum[22:0];
        end else begin
            ramp_next = ramp_reg;
        end
        sum_next = sum_reg + 57'(lane_res[k_reg].square);
    end

    assign start_next = ((state_reg == T_IDLE) && s_valid && s_command_mode && !homing_reg)
                     || ((state_reg == T_RAMP) && (k_reg == LAST_JOINT));
    assign out_load   = (state_reg == T_OUT) && (!m_valid_reg || m_ready);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == T_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= T_IDLE;
            tick_period_reg <= 32'd4294967;
            speed_step_reg  <= 16'd168;
            speed_cap_reg   <= 24'd3355443;
            homing_reg      <= 1'b1;
            ramp_reg        <= '0;
            start_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
            k_reg           <= '0;
            for (int j = 0; j < MAX_JOINTS; j++) begin
                cmd_reg[j] <= '0;
                cnt_reg[j] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TICK_PERIOD: tick_period_reg <= cfg_data;
                    REG_SPEED_STEP:  speed_step_reg  <= cfg_data[15:0];
                    REG_SPEED_CAP:   speed_cap_reg   <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            start_reg <= start_next;
            unique case (state_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        for (int j = 0; j < MAX_JOINTS; j++) begin
                            meas_reg[j] <= (j < NUM_JOINTS) ? in_meas[j] : '0;
                        end
                        if (!s_command_mode) begin
                            for (int j = 0; j < MAX_JOINTS; j++) begin
                                cmd_reg[j] <= (j < NUM_JOINTS) ? in_meas[j] : '0;
                            end
                        end else if (homing_reg) begin
                            k_reg     <= '0;
                            state_reg <= T_RAMP;
                        end else begin
                            state_reg <= T_LANES;
                        end
                    end
                end
                T_RAMP: begin
                    // each joint sees the speed before its own increment
                    lane_ramp_reg[k_reg] <= ramp_reg;
                    ramp_reg             <= ramp_next;
                    k_reg                <= k_reg + 3'd1;
                    if (k_reg == LAST_JOINT) begin
                        state_reg <= T_LANES;
                    end
                end
                T_LANES: begin
                    if (all_done) begin
                        for (int j = 0; j < NUM_JOINTS; j++) begin
                            if (homing_reg) begin
                                cmd_reg[j] <= lane_res[j].cmd;
                            end else if (lane_res[j].active) begin
                                cmd_reg[j] <= lane_res[j].cmd;
                                cnt_reg[j] <= cnt_reg[j] + 32'd1;
                            end
                        end
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= homing_reg ? T_MERGE : T_OUT;
                    end
                end
                T_MERGE: begin
                    sum_reg <= sum_next;
                    k_reg   <= k_reg + 3'd1;
                    if (k_reg == LAST_JOINT) begin
                        if (sum_next < NORM_THR) begin
                            homing_reg <= 1'b0;
                        end
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (out_load) begin
                        for (int j = 0; j < MAX_JOINTS; j++) begin
                            out_cmd_reg[j] <= (j < NUM_JOINTS) ? cmd_reg[j] : '0;
                        end
                        out_homing_reg <= homing_reg;
                        state_reg      <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cmd_j0        = out_cmd_reg[0];
    assign m_cmd_j1        = out_cmd_reg[1];
    assign m_cmd_j2        = out_cmd_reg[2];
    assign m_cmd_j3        = out_cmd_reg[3];
    assign m_cmd_j4        = out_cmd_reg[4];
    assign m_cmd_j5        = out_cmd_reg[5];
    assign m_cmd_j6        = out_cmd_reg[6];
    assign m_homing_active = out_homing_reg;

endmodule
